[src/jtl_pkg.sv]
`timescale 1ns / 1ps

package jtl_pkg;

    // Depth of the result queue at the output. It must hold at least two
    // words so that a byte that completes two tokens can always be taken.
    localparam int QueueDepth = 4;
    localparam int CountW     = $clog2(QueueDepth + 1);

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_STRING  = 2'd1,
        MODE_NUMBER  = 2'd2,
        MODE_KEYWORD = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        TK_OBJSTART     = 4'd0,
        TK_OBJEND       = 4'd1,
        TK_COMMA        = 4'd2,
        TK_COLON        = 4'd3,
        TK_ARRSTART     = 4'd4,
        TK_ARREND       = 4'd5,
        TK_STRING       = 4'd6,
        TK_NUMBER       = 4'd7,
        TK_BOOL         = 4'd8,
        TK_EOF          = 4'd9,
        TK_UNKNOWN      = 4'd10,
        TK_UNTERMINATED = 4'd11
    } t_token;

    // Event kinds.
    localparam logic EV_LEXEME = 1'b0;
    localparam logic EV_TOKEN  = 1'b1;

    // Characters the lexer reacts to.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [2:0] LEN_TRUE  = 3'd4;
    localparam logic [2:0] LEN_FALSE = 3'd5;

    typedef struct packed {
        logic       event_kind;
        t_token     token_kind;
        logic [7:0] lexeme_byte;
        logic       bool_value;
        logic       last_of_run;
    } t_result;

    // Expected keyword character at a given position of "true" or "false".
    function automatic logic [7:0] kw_char(input logic is_true, input logic [2:0] pos);
        logic [7:0] ch;
        ch = CH_NUL;
        if (is_true) begin
            case (pos)
                3'd0:    ch = CH_T;
                3'd1:    ch = CH_R;
                3'd2:    ch = CH_U;
                3'd3:    ch = CH_E;
                default: ch = CH_NUL;
            endcase
        end else begin
            case (pos)
                3'd0:    ch = CH_F;
                3'd1:    ch = CH_A;
                3'd2:    ch = CH_L;
                3'd3:    ch = CH_S;
                3'd4:    ch = CH_E;
                default: ch = CH_NUL;
            endcase
        end
        return ch;
    endfunction

endpackage

[src/json_token_lexer.sv]
`timescale 1ns / 1ps

// Streaming lexer for a subset of JSON text, one character per word.
//
// Input channel: i_valid / o_stall carry one character in i_char_in. A zero
// character marks end of input and yields an eof token, or an unterminated
// token inside a string; lexing then simply continues. Output channel:
// o_valid / i_stall carry one result word, either a lexeme byte of the
// current string or number, or a completed token. A character gives zero,
// one or two result words; o_last_of_run marks the final word caused by
// that character.
// The character is decoded in the cycle it is taken and its results sit in
// the output queue from the next edge on. One character is accepted every
// cycle as long as the four-word output queue has room for two more words,
// so throughput is one character per clock while the receiver keeps up.
// When the receiver stalls, the queue fills and o_stall rises once fewer
// than two entries are free; the head word holds steady until it is taken.
//
// Synchronous active-low reset returns the lexer to the between-tokens mode
// and empties the output queue.
module json_token_lexer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_event_kind,
    output logic [3:0] o_token_kind,
    output logic [7:0] o_lexeme_byte,
    output logic       o_bool_value,
    output logic       o_last_of_run
);
    import jtl_pkg::*;

    // Lexer state.
    t_mode       r_mode, n_mode;
    logic [2:0]  r_kw_pos, n_kw_pos;
    logic        r_kw_is_true, n_kw_is_true;
    logic        r_kw_matching, n_kw_matching;

    // Output queue: entry 0 is always the head, so every entry is read at a
    // fixed place and the queue shifts down on each pop.
    t_result     r_q [QueueDepth];
    t_result     n_q [QueueDepth];
    t_result     shifted [QueueDepth];
    logic [CountW-1:0] r_count, n_count;

    // Decode results for the current character.
    t_result     idle_res;
    logic        idle_has;
    t_mode       idle_mode;
    logic        idle_kw_start;
    t_result     res0, res1;
    logic [1:0]  num_res;
    logic        is_digit;
    logic [2:0]  kw_len;
    logic [2:0]  kw_pos;
    logic        kw_match;

    logic        in_accept;
    logic        out_pop;
    logic [1:0]  push_cnt;
    logic [CountW-1:0] count_after;

    assign in_accept = i_valid && !o_stall;
    assign out_pop   = o_valid && !i_stall;
    assign is_digit  = (i_char_in >= CH_ZERO) && (i_char_in <= CH_NINE);

    // How a character is handled between tokens. A number that ends on a
    // non-digit hands that character to this same decode.
    always_comb begin
        idle_has      = 1'b0;
        idle_mode     = MODE_IDLE;
        idle_kw_start = 1'b0;
        idle_res      = '{event_kind: EV_TOKEN, token_kind: TK_UNKNOWN,
                          lexeme_byte: 8'd0, bool_value: 1'b0, last_of_run: 1'b0};
        unique case (i_char_in) inside
            CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
                idle_has = 1'b0;
            end
            CH_LBRACE: begin
                idle_has = 1'b1;
                idle_res.token_kind = TK_OBJSTART;
            end
            CH_RBRACE: begin
                idle_has = 1'b1;
                idle_res.token_kind = TK_OBJEND;
            end
            CH_COMMA: begin
                idle_has = 1'b1;
                idle_res.token_kind = TK_COMMA;
            end
            CH_COLON: begin
                idle_has = 1'b1;
                idle_res.token_kind = TK_COLON;
            end
            CH_LBRACK: begin
                idle_has = 1'b1;
                idle_res.token_kind = TK_ARRSTART;
            end
            CH_RBRACK: begin
                idle_has = 1'b1;
                idle_res.token_kind = TK_ARREND;
            end
            CH_NUL: begin
                idle_has = 1'b1;
                idle_res.token_kind = TK_EOF;
            end
            CH_QUOTE: begin
                idle_mode = MODE_STRING;
            end
            CH_T, CH_F: begin
                idle_mode     = MODE_KEYWORD;
                idle_kw_start = 1'b1;
            end
            [CH_ZERO:CH_NINE]: begin
                idle_has             = 1'b1;
                idle_mode            = MODE_NUMBER;
                idle_res.event_kind  = EV_LEXEME;
                idle_res.token_kind  = TK_NUMBER;
                idle_res.lexeme_byte = i_char_in;
            end
            default: begin
                idle_has = 1'b1;
            end
        endcase
    end

    // Next lexer state and the up to two results of this character.
    always_comb begin
        n_mode        = r_mode;
        n_kw_pos      = r_kw_pos;
        n_kw_is_true  = r_kw_is_true;
        n_kw_matching = r_kw_matching;
        res0          = '{event_kind: EV_TOKEN, token_kind: TK_UNKNOWN,
                          lexeme_byte: 8'd0, bool_value: 1'b0, last_of_run: 1'b0};
        res1          = res0;
        num_res       = 2'd0;
        kw_len        = r_kw_is_true ? LEN_TRUE : LEN_FALSE;
        kw_pos        = r_kw_pos;
        kw_match      = r_kw_matching;

        unique case (r_mode)
            MODE_STRING: begin
                num_res = 2'd1;
                if (i_char_in == CH_QUOTE) begin
                    n_mode          = MODE_IDLE;
                    res0.token_kind = TK_STRING;
                end else if (i_char_in == CH_NUL) begin
                    n_mode          = MODE_IDLE;
                    res0.token_kind = TK_UNTERMINATED;
                end else begin
                    res0.event_kind  = EV_LEXEME;
                    res0.token_kind  = TK_STRING;
                    res0.lexeme_byte = i_char_in;
                end
            end
            MODE_NUMBER: begin
                if (is_digit) begin
                    num_res          = 2'd1;
                    res0.event_kind  = EV_LEXEME;
                    res0.token_kind  = TK_NUMBER;
                    res0.lexeme_byte = i_char_in;
                end else begin
                    // Close the number, then lex the character afresh.
                    n_mode          = idle_mode;
                    res0.token_kind = TK_NUMBER;
                    res1            = idle_res;
                    num_res         = idle_has ? 2'd2 : 2'd1;
                    if (idle_kw_start) begin
                        n_kw_is_true  = (i_char_in == CH_T);
                        n_kw_pos      = 3'd1;
                        n_kw_matching = 1'b1;
                    end
                end
            end
            MODE_KEYWORD: begin
                if (kw_pos < kw_len) begin
                    if (i_char_in != kw_char(r_kw_is_true, kw_pos)) begin
                        kw_match = 1'b0;
                    end
                    kw_pos = kw_pos + 3'd1;
                end
                n_kw_pos      = kw_pos;
                n_kw_matching = kw_match;
                if (i_char_in == CH_NUL) begin
                    n_mode          = MODE_IDLE;
                    n_kw_pos        = 3'd0;
                    res0.token_kind = TK_UNKNOWN;
                    res1.token_kind = TK_EOF;
                    num_res         = 2'd2;
                end else if (kw_pos >= kw_len) begin
                    n_mode        = MODE_IDLE;
                    n_kw_pos      = 3'd0;
                    n_kw_matching = 1'b1;
                    num_res       = 2'd1;
                    if (kw_match) begin
                        res0.token_kind = TK_BOOL;
                        res0.bool_value = r_kw_is_true;
                    end else begin
                        res0.token_kind = TK_UNKNOWN;
                    end
                end
            end
            MODE_IDLE: begin
                n_mode  = idle_mode;
                res0    = idle_res;
                num_res = idle_has ? 2'd1 : 2'd0;
                if (idle_kw_start) begin
                    n_kw_is_true  = (i_char_in == CH_T);
                    n_kw_pos      = 3'd1;
                    n_kw_matching = 1'b1;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase

        if (num_res == 2'd1) begin
            res0.last_of_run = 1'b1;
        end
        if (num_res == 2'd2) begin
            res1.last_of_run = 1'b1;
        end
    end

    // Queue update: pop from the head, then append this character's results.
    assign push_cnt    = in_accept ? num_res : 2'd0;
    assign count_after = r_count - CountW'(out_pop);

    always_comb begin
        shifted[QueueDepth-1] = r_q[QueueDepth-1];
        for (int j = 0; j < QueueDepth - 1; j++) begin
            shifted[j] = r_q[j + 1];
        end
        for (int j = 0; j < QueueDepth; j++) begin
            if (CountW'(j) < count_after) begin
                n_q[j] = out_pop ? shifted[j] : r_q[j];
            end else if (CountW'(j) == count_after && push_cnt != 2'd0) begin
                n_q[j] = res0;
            end else if (CountW'(j) == count_after + CountW'(1) && push_cnt == 2'd2) begin
                n_q[j] = res1;
            end else begin
                n_q[j] = r_q[j];
            end
        end
        n_count = count_after + CountW'(push_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_kw_pos      <= 3'd0;
            r_kw_is_true  <= 1'b0;
            r_kw_matching <= 1'b1;
            r_count       <= '0;
        end else begin
            if (in_accept) begin
                r_mode        <= n_mode;
                r_kw_pos      <= n_kw_pos;
                r_kw_is_true  <= n_kw_is_true;
                r_kw_matching <= n_kw_matching;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < QueueDepth; j++) begin
            r_q[j] <= n_q[j];
        end
    end

    // Room for two words is required before a character is taken.
    assign o_stall       = (r_count > CountW'(QueueDepth - 2));
    assign o_valid       = (r_count != '0);
    assign o_event_kind  = r_q[0].event_kind;
    assign o_token_kind  = r_q[0].token_kind;
    assign o_lexeme_byte = r_q[0].lexeme_byte;
    assign o_bool_value  = r_q[0].bool_value;
    assign o_last_of_run = r_q[0].last_of_run;

    // The queue never holds more words than it has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(QueueDepth))
        else $error("output queue overflow");

    // Inside a keyword the position stays strictly within the word.
    a_kw_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_KEYWORD) |->
            (r_kw_pos != 3'd0 && r_kw_pos < (r_kw_is_true ? LEN_TRUE : LEN_FALSE)))
        else $error("keyword position out of range");

    // Outside a keyword the position has been cleared.
    a_kw_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_KEYWORD) |-> (r_kw_pos == 3'd0))
        else $error("keyword position left set");

    // A lexeme byte only ever belongs to a string or a number.
    a_lexeme_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_kind == EV_LEXEME) |->
            (o_token_kind == TK_STRING || o_token_kind == TK_NUMBER))
        else $error("lexeme byte with wrong token kind");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the streaming JSON lexer.
//
// A queue of characters is built up front: a short directed text that hits
// every token kind and the corner cases, then random fragments that look
// like JSON (punctuation, strings, numbers, keywords) mixed with whitespace,
// stray bytes and broken sequences. A negedge driver feeds the queue in
// bursts. A posedge monitor runs every accepted character through a local
// lexer model and checks each accepted result word against the oldest
// expected word.
module tb;

    import jtl_pkg::*;

    // One entry of the feed queue. A pause entry makes the driver hold off
    // until every expected word has been taken.
    typedef struct packed {
        logic       pause;
        logic [7:0] ch;
    } t_feed_item;

    // Keyword spellings, first character in the top byte.
    localparam logic [31:0] TXT_TRUE  = "true";
    localparam logic [39:0] TXT_FALSE = "false";

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_char_in = 8'h00;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_event_kind;
    logic [3:0] o_token_kind;
    logic [7:0] o_lexeme_byte;
    logic       o_bool_value;
    logic       o_last_of_run;

    json_token_lexer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_char_in     (i_char_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_event_kind  (o_event_kind),
        .o_token_kind  (o_token_kind),
        .o_lexeme_byte (o_lexeme_byte),
        .o_bool_value  (o_bool_value),
        .o_last_of_run (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // This bound leaves a wide margin over a normal run, even under the
    // heaviest stall pattern.
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Lexer model. It keeps its own copy of the mode and keyword tracking
    // and appends the words a character is expected to produce.
    // ------------------------------------------------------------------
    t_mode      lx_mode = MODE_IDLE;
    logic [2:0] kw_pos  = 3'd0;
    logic       kw_true = 1'b0;
    logic       kw_ok   = 1'b1;

    t_result    expected_words[$];
    t_feed_item feed_queue[$];

    int errors         = 0;
    int chars_queued   = 0;
    int chars_fed      = 0;
    int words_seen     = 0;
    int lexeme_words   = 0;
    int pauses_done    = 0;
    int long_holds     = 0;
    int token_tally[12];

    // Handshake seen at the last rising edge; the driver reads it at the
    // following falling edge.
    logic char_taken = 1'b0;

    function automatic void expect_word(logic ev, t_token tk, logic [7:0] b, logic bv);
        t_result w;
        w.event_kind  = ev;
        w.token_kind  = tk;
        w.lexeme_byte = b;
        w.bool_value  = bv;
        w.last_of_run = 1'b0;
        expected_words.push_back(w);
    endfunction

    function automatic bit is_digit_char(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // A character seen between tokens gives at most one word.
    function automatic void lex_between_tokens(logic [7:0] c);
        case (c)
            CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
            CH_LBRACE: expect_word(EV_TOKEN, TK_OBJSTART, 8'h00, 1'b0);
            CH_RBRACE: expect_word(EV_TOKEN, TK_OBJEND, 8'h00, 1'b0);
            CH_COMMA:  expect_word(EV_TOKEN, TK_COMMA, 8'h00, 1'b0);
            CH_COLON:  expect_word(EV_TOKEN, TK_COLON, 8'h00, 1'b0);
            CH_LBRACK: expect_word(EV_TOKEN, TK_ARRSTART, 8'h00, 1'b0);
            CH_RBRACK: expect_word(EV_TOKEN, TK_ARREND, 8'h00, 1'b0);
            CH_NUL:    expect_word(EV_TOKEN, TK_EOF, 8'h00, 1'b0);
            CH_QUOTE:  lx_mode = MODE_STRING;
            CH_T, CH_F: begin
                lx_mode = MODE_KEYWORD;
                kw_true = (c == CH_T);
                kw_pos  = 3'd1;
                kw_ok   = 1'b1;
            end
            default: begin
                if (is_digit_char(c)) begin
                    lx_mode = MODE_NUMBER;
                    expect_word(EV_LEXEME, TK_NUMBER, c, 1'b0);
                end else begin
                    expect_word(EV_TOKEN, TK_UNKNOWN, 8'h00, 1'b0);
                end
            end
        endcase
    endfunction

    function automatic void lex_char(logic [7:0] c);
        int         first;
        int         len;
        int         pos;
        logic [7:0] want;
        first = expected_words.size();
        case (lx_mode)
            MODE_STRING: begin
                if (c == CH_QUOTE) begin
                    lx_mode = MODE_IDLE;
                    expect_word(EV_TOKEN, TK_STRING, 8'h00, 1'b0);
                end else if (c == CH_NUL) begin
                    lx_mode = MODE_IDLE;
                    expect_word(EV_TOKEN, TK_UNTERMINATED, 8'h00, 1'b0);
                end else begin
                    expect_word(EV_LEXEME, TK_STRING, c, 1'b0);
                end
            end
            MODE_NUMBER: begin
                if (is_digit_char(c)) begin
                    expect_word(EV_LEXEME, TK_NUMBER, c, 1'b0);
                end else begin
                    // The number closes and the same character is then
                    // lexed as if it had come between tokens.
                    lx_mode = MODE_IDLE;
                    expect_word(EV_TOKEN, TK_NUMBER, 8'h00, 1'b0);
                    lex_between_tokens(c);
                end
            end
            MODE_KEYWORD: begin
                len = kw_true ? 4 : 5;
                pos = kw_pos;
                if (pos < len) begin
                    want = kw_true ? TXT_TRUE[8*(3-pos) +: 8] : TXT_FALSE[8*(4-pos) +: 8];
                    if (c != want)
                        kw_ok = 1'b0;
                    pos++;
                end
                kw_pos = pos[2:0];
                if (c == CH_NUL) begin
                    // End of input cuts the keyword short: unknown, then eof.
                    lx_mode = MODE_IDLE;
                    kw_pos  = 3'd0;
                    expect_word(EV_TOKEN, TK_UNKNOWN, 8'h00, 1'b0);
                    expect_word(EV_TOKEN, TK_EOF, 8'h00, 1'b0);
                end else if (pos >= len) begin
                    lx_mode = MODE_IDLE;
                    kw_pos  = 3'd0;
                    if (kw_ok)
                        expect_word(EV_TOKEN, TK_BOOL, 8'h00, kw_true);
                    else
                        expect_word(EV_TOKEN, TK_UNKNOWN, 8'h00, 1'b0);
                    kw_ok = 1'b1;
                end
            end
            default: lex_between_tokens(c);
        endcase
        if (expected_words.size() > first)
            expected_words[expected_words.size() - 1].last_of_run = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Feed queue helpers.
    // ------------------------------------------------------------------
    function automatic void queue_char(logic [7:0] c);
        feed_queue.push_back({1'b0, c});
        chars_queued++;
    endfunction

    function automatic void queue_text(string s);
        int k;
        for (k = 0; k < s.len(); k++)
            queue_char(s[k]);
    endfunction

    function automatic void queue_pause();
        feed_queue.push_back({1'b1, 8'h00});
    endfunction

    // ------------------------------------------------------------------
    // Driver. A new word is chosen only when the line is idle or the
    // current word was taken at the last edge, so a stalled word stays put.
    // Bursts of random length alternate with gaps, and about a third of
    // the bursts run straight into the next one with no gap at all.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin : feeder
        t_feed_item item;
        logic       next_valid;
        logic [7:0] next_char;
        next_valid = i_valid;
        next_char  = i_char_in;
        if (i_rst_n && (!i_valid || char_taken)) begin
            next_valid = 1'b0;
            next_char  = 8'($urandom_range(0, 255));
            if (gap_left > 0) begin
                gap_left--;
            end else if (feed_queue.size() > 0) begin
                if (feed_queue[0].pause) begin
                    // Hold off until the lexer has delivered everything.
                    if (expected_words.size() == 0) begin
                        void'(feed_queue.pop_front());
                        pauses_done++;
                    end
                end else begin
                    item       = feed_queue.pop_front();
                    next_valid = 1'b1;
                    next_char  = item.ch;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
        i_valid   <= next_valid;
        i_char_in <= next_char;
    end

    // ------------------------------------------------------------------
    // Receiver. It stalls on one of four patterns (none, light, half, heavy),
    // picked at random and redrawn periodically. Twice it holds off while the
    // sender is offering, so the output queue fills and the lexer stalls its input.
    // ------------------------------------------------------------------
    int rx_cycles  = 0;
    int rx_pattern = 0;
    int hold_left  = 0;

    always @(negedge i_clk) begin : receiver
        logic hold;
        hold = 1'b0;
        if (i_rst_n) begin
            rx_cycles++;
            if (hold_left > 0) begin
                hold_left--;
                hold = 1'b1;
            end else if (long_holds < 2 && i_valid
                         && words_seen >= (long_holds == 0 ? 300 : 900)) begin
                hold_left = 79;
                long_holds++;
                hold = 1'b1;
            end else begin
                if (rx_cycles % 150 == 0)
                    rx_pattern = $urandom_range(0, 3);
                case (rx_pattern)
                    0:       hold = 1'b0;
                    1:       hold = ($urandom_range(0, 7) == 0);
                    2:       hold = $urandom_range(0, 1);
                    default: hold = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
        i_stall <= hold;
    end

    // ------------------------------------------------------------------
    // Monitor. Inputs are predicted before outputs are checked, so a word
    // caused by a character taken at this same edge would still be found.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result want;
        char_taken = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                char_taken = 1'b1;
                chars_fed++;
                lex_char(i_char_in);
            end
            if (o_valid && !i_stall) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word ev=%0d tk=%0d byte=%02h bool=%0d last=%0d",
                             $time, o_event_kind, o_token_kind, o_lexeme_byte,
                             o_bool_value, o_last_of_run);
                end else begin
                    want = expected_words.pop_front();
                    if (o_event_kind !== want.event_kind || o_token_kind !== want.token_kind
                        || o_lexeme_byte !== want.lexeme_byte
                        || o_bool_value !== want.bool_value
                        || o_last_of_run !== want.last_of_run) begin
                        errors++;
                        $display("%0t: word %0d expected ev=%0d tk=%0d byte=%02h bool=%0d last=%0d",
                                 $time, words_seen, want.event_kind, want.token_kind,
                                 want.lexeme_byte, want.bool_value, want.last_of_run);
                        $display("%0t: word %0d actual   ev=%0d tk=%0d byte=%02h bool=%0d last=%0d",
                                 $time, words_seen, o_event_kind, o_token_kind,
                                 o_lexeme_byte, o_bool_value, o_last_of_run);
                    end
                    if (want.event_kind == EV_LEXEME)
                        lexeme_words++;
                    else
                        token_tally[want.token_kind]++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] punct [0:5];
        logic [7:0] ws    [0:3];
        logic [7:0] b;
        string      kw_text;
        int         pick;
        int         n;
        int         k;
        int         bad;
        int         next_pause;

        punct = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COMMA, CH_COLON};
        ws    = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
        foreach (token_tally[k])
            token_tally[k] = 0;

        // Directed part: every punctuation token, a zero digit ended by a
        // comma, a number ended by a colon, all four whitespace characters,
        // both keywords, a keyword cut short by end of input, a string cut
        // short by end of input, a number ended by end of input (and lexing
        // that goes on after eof), and a byte with every bit set.
        queue_text("[0,\"a\"]");
        queue_text("{9:}");
        queue_text(" \t\n\r");
        queue_text("true");
        queue_text("false");
        queue_text("fa");
        queue_char(CH_NUL);
        queue_char(CH_QUOTE);
        queue_char(CH_NUL);
        queue_text("5");
        queue_char(CH_NUL);
        queue_char(8'hFF);
        queue_pause();

        // Random part: mostly JSON-shaped fragments with random content,
        // plus noise bytes and broken keywords and strings.
        next_pause = chars_queued + 500;
        while (chars_queued < 1630) begin
            if (chars_queued >= next_pause) begin
                queue_pause();
                next_pause += 500;
            end
            pick = $urandom_range(0, 19);
            if (pick <= 5) begin
                queue_char(punct[$urandom_range(0, 5)]);
            end else if (pick <= 7) begin
                queue_char(ws[$urandom_range(0, 3)]);
            end else if (pick <= 10) begin
                n = $urandom_range(0, 6);
                queue_char(CH_QUOTE);
                repeat (n) begin
                    do
                        b = 8'($urandom_range(1, 255));
                    while (b == CH_QUOTE);
                    queue_char(b);
                end
                queue_char(($urandom_range(0, 9) == 0) ? CH_NUL : CH_QUOTE);
            end else if (pick <= 13) begin
                // The terminator comes from whatever fragment follows.
                n = $urandom_range(1, 5);
                repeat (n)
                    queue_char(CH_ZERO + 8'($urandom_range(0, 9)));
            end else if (pick <= 16) begin
                kw_text = $urandom_range(0, 1) ? "true" : "false";
                bad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, kw_text.len() - 1) : 0;
                for (k = 0; k < kw_text.len(); k++) begin
                    b = kw_text[k];
                    if (bad != 0 && k == bad)
                        b = ($urandom_range(0, 7) == 0) ? CH_NUL : 8'($urandom_range(0, 255));
                    queue_char(b);
                end
            end else if (pick == 17) begin
                queue_char(CH_NUL);
            end else begin
                queue_char(8'($urandom_range(0, 255)));
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_queue.size() > 0 || i_valid)
            @(posedge i_clk);
        while (expected_words.size() > 0)
            @(posedge i_clk);
        // A further wait catches any stray word.
        repeat (10) @(posedge i_clk);

        $display("Lexed %0d characters into %0d words: %0d lexeme bytes, %0d string, %0d number,",
                 chars_fed, words_seen, lexeme_words, token_tally[TK_STRING],
                 token_tally[TK_NUMBER]);
        $display("%0d bool, %0d eof, %0d unknown, %0d unterminated; %0d drains, %0d long holds.",
                 token_tally[TK_BOOL], token_tally[TK_EOF], token_tally[TK_UNKNOWN],
                 token_tally[TK_UNTERMINATED], pauses_done, long_holds);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
